>>> rtl/core/sftr_pkg.sv
// Shared constants, types and tables for the scaled text renderer.
// Used by every file of the block but sftr_ifs; depends on nothing else.
`default_nettype none

package sftr_pkg;

	// Display geometry and frame store layout.
	localparam int DISPLAY_WIDTH  = 128;
	localparam int DISPLAY_HEIGHT = 64;
	localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
	localparam int STORE_BYTES    = DISPLAY_WIDTH * PAGE_COUNT;
	localparam int ADDR_W         = $clog2(STORE_BYTES);

	// Rows of the last page that lie on the panel.
	localparam logic [7:0] LAST_PAGE_MASK = (DISPLAY_HEIGHT % 8 == 0) ? 8'hFF :
		8'((1 << (DISPLAY_HEIGHT % 8)) - 1);

	// Font.
	localparam int         GLYPH_COLS  = 5;
	localparam int         STRIP_W     = 64;
	localparam logic [7:0] FIRST_CODE  = 8'h20;
	localparam logic [7:0] LAST_CODE   = 8'h7E;
	localparam logic [2:0] SCALE_RESET = 3'd3;

	// Item kinds.
	localparam logic [1:0] KIND_DRAW  = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	typedef enum logic [1:0] {
		WK_IDLE,
		WK_LOAD,
		WK_EMIT
	} walk_state_t;

	typedef enum logic [2:0] {
		CT_IDLE,
		CT_DRAW,
		CT_CLEAR,
		CT_READ,
		CT_HOLD
	} ctl_state_t;

	typedef struct packed {
		logic       start;
		logic [7:0] x0;
		logic [7:0] y0;
		logic [7:0] code;
		logic [2:0] scale;
	} walk_cmd_t;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        mask;
	} rmw_op_t;

	// Expands one glyph column vertically: font row j covers rows j*s .. j*s+s-1.
	function automatic logic [55:0] scale_col(input logic [7:0] bits, input logic [2:0] s);
		logic [55:0] r;
		r = '0;
		for (int sv = 1; sv < 8; sv++) begin
			if (s == 3'(sv)) begin
				for (int j = 0; j < 8; j++) begin
					for (int b = 0; b < sv; b++) begin
						r[j * sv + b] = bits[j];
					end
				end
			end
		end
		return r;
	endfunction

	// Glyph ROM for codes 0x20..0x7E. Column 0 is the most significant byte.
	function automatic logic [39:0] glyph_bits(input logic [6:0] idx);
		logic [39:0] g;
		case (idx)
			7'd0:  g = 40'h0000000000;
			7'd1:  g = 40'h00005F0000;
			7'd2:  g = 40'h0003000300;
			7'd3:  g = 40'h147F147F14;
			7'd4:  g = 40'h242A7F2A12;
			7'd5:  g = 40'h2313086462;
			7'd6:  g = 40'h3649552250;
			7'd7:  g = 40'h0005030000;
			7'd8:  g = 40'h001C224100;
			7'd9:  g = 40'h0041221C00;
			7'd10: g = 40'h14083E0814;
			7'd11: g = 40'h08083E0808;
			7'd12: g = 40'h0050300000;
			7'd13: g = 40'h0808080808;
			7'd14: g = 40'h0060600000;
			7'd15: g = 40'h2010080402;
			7'd16: g = 40'h3E5149453E;
			7'd17: g = 40'h00427F4000;
			7'd18: g = 40'h4261514946;
			7'd19: g = 40'h2141454B31;
			7'd20: g = 40'h1814127F10;
			7'd21: g = 40'h2745454539;
			7'd22: g = 40'h3C4A494930;
			7'd23: g = 40'h0171090503;
			7'd24: g = 40'h3649494936;
			7'd25: g = 40'h264949493E;
			7'd26: g = 40'h0036360000;
			7'd27: g = 40'h0056360000;
			7'd28: g = 40'h0008142241;
			7'd29: g = 40'h1414141414;
			7'd30: g = 40'h4122140800;
			7'd31: g = 40'h0201510906;
			7'd32: g = 40'h324979413E;
			7'd33: g = 40'h7E1111117E;
			7'd34: g = 40'h7F49494936;
			7'd35: g = 40'h3E41414122;
			7'd36: g = 40'h7F4141221C;
			7'd37: g = 40'h7F49494941;
			7'd38: g = 40'h7F09090101;
			7'd39: g = 40'h3E4149497A;
			7'd40: g = 40'h7F0808087F;
			7'd41: g = 40'h00417F4100;
			7'd42: g = 40'h2040413F01;
			7'd43: g = 40'h7F08142241;
			7'd44: g = 40'h7F40404040;
			7'd45: g = 40'h7F0204027F;
			7'd46: g = 40'h7F0408107F;
			7'd47: g = 40'h3E4141413E;
			7'd48: g = 40'h7F09090906;
			7'd49: g = 40'h3E4151215E;
			7'd50: g = 40'h7F09192946;
			7'd51: g = 40'h4649494931;
			7'd52: g = 40'h01017F0101;
			7'd53: g = 40'h3F4040403F;
			7'd54: g = 40'h1F2040201F;
			7'd55: g = 40'h3F4030403F;
			7'd56: g = 40'h6314081463;
			7'd57: g = 40'h0304780403;
			7'd58: g = 40'h6151494543;
			7'd59: g = 40'h00007F4141;
			7'd60: g = 40'h0204081020;
			7'd61: g = 40'h41417F0000;
			7'd62: g = 40'h0402010204;
			7'd63: g = 40'h4040404040;
			7'd64: g = 40'h0001020000;
			7'd65: g = 40'h2054545478;
			7'd66: g = 40'h7F48444438;
			7'd67: g = 40'h3844444420;
			7'd68: g = 40'h384444487F;
			7'd69: g = 40'h3854545418;
			7'd70: g = 40'h087E090102;
			7'd71: g = 40'h08143E0101;
			7'd72: g = 40'h7F08040478;
			7'd73: g = 40'h00447D4000;
			7'd74: g = 40'h4080847D00;
			7'd75: g = 40'h7F10284400;
			7'd76: g = 40'h007F404000;
			7'd77: g = 40'h78047C0478;
			7'd78: g = 40'h7C08040478;
			7'd79: g = 40'h3844444438;
			7'd80: g = 40'h7C14141408;
			7'd81: g = 40'h081414187C;
			7'd82: g = 40'h7C08040408;
			7'd83: g = 40'h4854545420;
			7'd84: g = 40'h043F444020;
			7'd85: g = 40'h3C4040207C;
			7'd86: g = 40'h1C2040201C;
			7'd87: g = 40'h3C4030403C;
			7'd88: g = 40'h4428102844;
			7'd89: g = 40'h0C5050503C;
			7'd90: g = 40'h4464544C44;
			7'd91: g = 40'h0008364100;
			7'd92: g = 40'h00007F0000;
			7'd93: g = 40'h0041360800;
			7'd94: g = 40'h08082A1C08;
			default: g = 40'h0000000000;
		endcase
		return g;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/sftr_ifs.sv
// Handshake channels of the scaled text renderer: request, response, configuration.
// Depends on nothing else.
`default_nettype none

interface sftr_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] char_code;
	logic       start_text;
	logic [7:0] start_x;
	logic [7:0] start_y;
	logic [9:0] read_index;

	modport source (output valid, kind, char_code, start_text, start_x, start_y, read_index,
		input ready);
	modport sink (input valid, kind, char_code, start_text, start_x, start_y, read_index,
		output ready);
endinterface

interface sftr_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic [7:0] cursor_x;
	logic [7:0] cursor_y;

	modport source (output valid, read_data, cursor_x, cursor_y, input ready);
	modport sink (input valid, read_data, cursor_x, cursor_y, output ready);
endinterface

interface sftr_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] font_scale;

	modport source (output valid, font_scale, input ready);
	modport sink (input valid, font_scale, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sftr_fstore.sv
// Frame store memory with a read-modify-write path and a clearing sweep.
// Depends on sftr_pkg.
`default_nettype none

module sftr_fstore (
	input  wire                          clk,
	input  wire                          arst_n,
	input  sftr_pkg::rmw_op_t            op,
	input  wire  [sftr_pkg::ADDR_W-1:0]  rd_addr,
	input  wire                          clr_start,
	output logic [7:0]                   rd_data,
	output logic                         clearing
);

	logic [7:0] mem [sftr_pkg::STORE_BYTES];

	logic                        op_valid_s1;
	logic [sftr_pkg::ADDR_W-1:0] addr_s1;
	logic [7:0]                  mask_s1;
	logic [7:0]                  rdata_q;

	logic                        clr_active_q;
	logic [sftr_pkg::ADDR_W-1:0] clr_cnt_q;

	logic [sftr_pkg::ADDR_W-1:0] raddr;
	logic                        wr_en;
	logic [sftr_pkg::ADDR_W-1:0] wr_addr;
	logic [7:0]                  wr_data;

	assign raddr = op.valid ? op.addr : rd_addr;

	always_comb begin
		if (clr_active_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_cnt_q;
			wr_data = 8'h00;
		end else begin
			wr_en   = op_valid_s1;
			wr_addr = addr_s1;
			wr_data = rdata_q | mask_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// A write to the entry being read is passed straight to the read data.
		if (wr_en && wr_addr == raddr) begin
			rdata_q <= wr_data;
		end else begin
			rdata_q <= mem[raddr];
		end
		addr_s1 <= op.addr;
		mask_s1 <= op.mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_valid_s1  <= 1'b0;
			clr_active_q <= 1'b1;
			clr_cnt_q    <= '0;
		end else begin
			op_valid_s1 <= op.valid;
			if (clr_start) begin
				clr_active_q <= 1'b1;
				clr_cnt_q    <= '0;
			end else if (clr_active_q) begin
				clr_cnt_q <= clr_cnt_q + sftr_pkg::ADDR_W'(1);
				if (clr_cnt_q == sftr_pkg::ADDR_W'(sftr_pkg::STORE_BYTES - 1)) begin
					clr_active_q <= 1'b0;
				end
			end
		end
	end

	assign rd_data  = rdata_q;
	assign clearing = clr_active_q;

endmodule

`default_nettype wire

>>> rtl/core/sftr_glyph_walk.sv
// Glyph walker: steps through the pixel columns and pages one glyph covers and issues
// one OR-mask update per covered frame store byte that is on the panel and has a nonzero mask. Depends on sftr_pkg.
`default_nettype none

module sftr_glyph_walk (
	input  wire                    clk,
	input  wire                    arst_n,
	input  sftr_pkg::walk_cmd_t    cmd,
	output sftr_pkg::rmw_op_t      op,
	output logic                   busy
);

	sftr_pkg::walk_state_t state_q, state_d;

	logic [7:0]                  x_q;
	logic [4:0]                  pg0_q;
	logic [2:0]                  ysh_q;
	logic [39:0]                 glyph_q;
	logic [2:0]                  s_q;
	logic [3:0]                  npg_q;
	logic [2:0]                  i_q;
	logic [2:0]                  a_q;
	logic [2:0]                  k_q;
	logic [sftr_pkg::STRIP_W-1:0] strip_q;

	logic       drawable;
	logic [6:0] rows_span;
	logic [3:0] npg_start;
	logic [7:0] col_bits;
	logic       last_k;
	logic       last_a;
	logic       last_i;
	logic [4:0] page;
	logic       on_panel;
	logic [7:0] row_mask;

	assign drawable = (cmd.code inside {[sftr_pkg::FIRST_CODE:sftr_pkg::LAST_CODE]}) &&
		(cmd.scale != 3'd0);
	// Pages touched: rows from the start row's offset in its page through 8*scale rows.
	assign rows_span = 7'(cmd.y0[2:0]) + 7'({cmd.scale, 3'b000}) + 7'd7;
	assign npg_start = rows_span[6:3];

	assign col_bits = glyph_q[8 * (sftr_pkg::GLYPH_COLS - 1 - int'(i_q)) +: 8];
	assign last_k   = ({1'b0, k_q} == npg_q - 4'd1);
	assign last_a   = (a_q == s_q - 3'd1);
	assign last_i   = (i_q == 3'(sftr_pkg::GLYPH_COLS - 1));

	assign page     = pg0_q + 5'(k_q);
	assign on_panel = (32'(x_q) < sftr_pkg::DISPLAY_WIDTH) &&
		(32'(page) < sftr_pkg::PAGE_COUNT);
	assign row_mask = (32'(page) == sftr_pkg::PAGE_COUNT - 1) ? sftr_pkg::LAST_PAGE_MASK : 8'hFF;

	always_comb begin
		state_d  = state_q;
		op.valid = 1'b0;
		op.addr  = sftr_pkg::ADDR_W'(32'(page) * sftr_pkg::DISPLAY_WIDTH + 32'(x_q));
		op.mask  = strip_q[8 * k_q +: 8] & row_mask;
		case (state_q)
			sftr_pkg::WK_IDLE: begin
				if (cmd.start && drawable) begin
					state_d = sftr_pkg::WK_LOAD;
				end
			end
			sftr_pkg::WK_LOAD: begin
				state_d = sftr_pkg::WK_EMIT;
			end
			sftr_pkg::WK_EMIT: begin
				op.valid = on_panel && (op.mask != 8'h00);
				if (last_k && last_a) begin
					state_d = last_i ? sftr_pkg::WK_IDLE : sftr_pkg::WK_LOAD;
				end
			end
			default: begin
				state_d = sftr_pkg::WK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sftr_pkg::WK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			sftr_pkg::WK_IDLE: begin
				x_q     <= cmd.x0;
				pg0_q   <= cmd.y0[7:3];
				ysh_q   <= cmd.y0[2:0];
				glyph_q <= sftr_pkg::glyph_bits(7'(cmd.code - sftr_pkg::FIRST_CODE));
				s_q     <= cmd.scale;
				npg_q   <= npg_start;
				i_q     <= 3'd0;
				a_q     <= 3'd0;
				k_q     <= 3'd0;
			end
			sftr_pkg::WK_LOAD: begin
				strip_q <= sftr_pkg::STRIP_W'(sftr_pkg::scale_col(col_bits, s_q)) << ysh_q;
			end
			sftr_pkg::WK_EMIT: begin
				if (last_k) begin
					k_q <= 3'd0;
					x_q <= x_q + 8'd1;
					if (last_a) begin
						a_q <= 3'd0;
						i_q <= i_q + 3'd1;
					end else begin
						a_q <= a_q + 3'd1;
					end
				end else begin
					k_q <= k_q + 3'd1;
				end
			end
			default: begin
				k_q <= 3'd0;
			end
		endcase
	end

	assign busy = (state_q != sftr_pkg::WK_IDLE);

endmodule

`default_nettype wire

>>> rtl/core/scaled_font_text_renderer.sv
// Scaled 5x8 text renderer over a page-organized 1-bit frame store.
// A draw with an unprintable code or scale 0 starts no glyph walk. A stalled response word
// delays the next word's response only while that word waits in CT_HOLD.
// One word in work at a time; the next is taken in CT_IDLE, once the response is parked.
// Reset is asynchronous; after it a clearing pass zeroes all 1024 store bytes.
// Depends on sftr_pkg, sftr_ifs, sftr_fstore and sftr_glyph_walk.
`default_nettype none

module scaled_font_text_renderer (
	input  wire          clk,
	input  wire          arst_n,
	sftr_req_if.sink     req,
	sftr_rsp_if.source   rsp,
	sftr_cfg_if.sink     cfg
);

	// The control FSM takes one word from req, runs it against the frame store,
	// then parks the response in the output register. The next request word is
	// accepted as soon as the response sits in that register, even while rsp stalls.
	sftr_pkg::ctl_state_t state_q, state_d;

	logic [2:0] font_scale_q;
	logic [7:0] cur_col_q;
	logic [7:0] cur_row_q;
	logic [7:0] res_data_q;
	logic       rd_oor_q;

	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic [7:0] out_x_q;
	logic [7:0] out_y_q;

	logic accept;
	logic out_load;
	logic clr_start;
	logic clearing;
	logic walk_busy;
	logic [7:0] rd_byte;

	sftr_pkg::walk_cmd_t walk_cmd;
	sftr_pkg::rmw_op_t   rmw_op;

	// Cursor arithmetic for a draw word.
	logic [7:0] x0;
	logic [7:0] y0;
	logic [5:0] adv5;
	logic [5:0] adv8;
	logic [8:0] x_sum;
	logic [9:0] edge_test;
	logic       line_wrap;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == sftr_pkg::CT_IDLE) && !clearing;
	assign cfg.ready = 1'b1;

	assign x0        = req.start_text ? req.start_x : cur_col_q;
	assign y0        = req.start_text ? req.start_y : cur_row_q;
	assign adv5      = 6'({font_scale_q, 2'b00}) + 6'(font_scale_q);
	assign adv8      = 6'({font_scale_q, 3'b000});
	assign x_sum     = 9'(x0) + 9'(adv5) + 9'd1;
	// The right-edge test uses the wrapped advance plus one more glyph width, unwrapped.
	assign edge_test = 10'(x_sum[7:0]) + 10'(adv5);
	assign line_wrap = (32'(edge_test) >= sftr_pkg::DISPLAY_WIDTH);

	always_comb begin
		state_d        = state_q;
		out_load       = 1'b0;
		clr_start      = 1'b0;
		walk_cmd.start = 1'b0;
		walk_cmd.x0    = x0;
		walk_cmd.y0    = y0;
		walk_cmd.code  = req.char_code;
		walk_cmd.scale = font_scale_q;
		case (state_q)
			sftr_pkg::CT_IDLE: begin
				if (accept) begin
					case (req.kind)
						sftr_pkg::KIND_DRAW: begin
							walk_cmd.start = 1'b1;
							state_d        = sftr_pkg::CT_DRAW;
						end
						sftr_pkg::KIND_CLEAR: begin
							clr_start = 1'b1;
							state_d   = sftr_pkg::CT_CLEAR;
						end
						sftr_pkg::KIND_READ: begin
							state_d = sftr_pkg::CT_READ;
						end
						default: begin
							state_d = sftr_pkg::CT_HOLD;
						end
					endcase
				end
			end
			sftr_pkg::CT_DRAW: begin
				// The last byte update lands at the edge that leaves this state, after the walker
				// goes idle.
				if (!walk_busy) begin
					state_d = sftr_pkg::CT_HOLD;
				end
			end
			sftr_pkg::CT_CLEAR: begin
				if (!clearing) begin
					state_d = sftr_pkg::CT_HOLD;
				end
			end
			sftr_pkg::CT_READ: begin
				state_d = sftr_pkg::CT_HOLD;
			end
			sftr_pkg::CT_HOLD: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = sftr_pkg::CT_IDLE;
				end
			end
			default: begin
				state_d = sftr_pkg::CT_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sftr_pkg::CT_IDLE;
			font_scale_q <= sftr_pkg::SCALE_RESET;
			cur_col_q    <= 8'd0;
			cur_row_q    <= 8'd0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				font_scale_q <= cfg.font_scale;
			end
			if (accept && req.kind == sftr_pkg::KIND_DRAW) begin
				cur_col_q <= line_wrap ? 8'd0 : x_sum[7:0];
				cur_row_q <= line_wrap ? y0 + 8'(adv8) : y0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Response payload; only read words carry store data.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_data_q <= 8'h00;
			rd_oor_q   <= (32'(req.read_index) >= sftr_pkg::STORE_BYTES);
		end else if (state_q == sftr_pkg::CT_READ) begin
			res_data_q <= rd_oor_q ? 8'h00 : rd_byte;
		end
		if (out_load) begin
			out_data_q <= res_data_q;
			out_x_q    <= cur_col_q;
			out_y_q    <= cur_row_q;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = out_data_q;
	assign rsp.cursor_x  = out_x_q;
	assign rsp.cursor_y  = out_y_q;

	sftr_glyph_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (walk_cmd),
		.op     (rmw_op),
		.busy   (walk_busy)
	);

	// The store is read every cycle; a read word's address is presented in its
	// acceptance cycle so the byte is ready in CT_READ.
	sftr_fstore u_fstore (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (rmw_op),
		.rd_addr   (sftr_pkg::ADDR_W'(req.read_index)),
		.clr_start (clr_start),
		.rd_data   (rd_byte),
		.clearing  (clearing)
	);

endmodule

`default_nettype wire

>>> rtl/core/sftr_checker.sv
// Port-level checks for the scaled text renderer, bound to its top level.
// Depends on sftr_pkg and scaled_font_text_renderer.
`default_nettype none

module sftr_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       req_valid,
	input wire       req_ready,
	input wire [1:0] req_kind,
	input wire       rsp_valid,
	input wire       rsp_ready,
	input wire [7:0] rsp_read_data,
	input wire [7:0] rsp_cursor_x,
	input wire [7:0] rsp_cursor_y
);

	// A stalled response word holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) &&
		$stable(rsp_cursor_x) && $stable(rsp_cursor_y))
		else $error("response word changed while stalled");

	// Only one request word is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted on consecutive cycles");

	// A clear sweeps the whole store before the next word; checked here only as req_ready low once the clear is taken.
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_kind == sftr_pkg::KIND_CLEAR |=>
		!req_ready ##1 !req_ready)
		else $error("request taken during a clear");

	// The clearing pass after reset blocks requests.
	a_reset_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !req_ready)
		else $error("request ready before the store was cleared");

endmodule

bind scaled_font_text_renderer sftr_checker u_sftr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_kind      (req.kind),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_read_data (rsp.read_data),
	.rsp_cursor_x  (rsp.cursor_x),
	.rsp_cursor_y  (rsp.cursor_y)
);

`default_nettype wire
